// File: sv/owtsm_pkg.sv
// Package for the single-wire temperature sensor master.
// Holds phase codes, command codes, register indexes and shared types.
package owtsm_pkg;

   localparam int CounterWidthDefault = 10;
   localparam int NumRegs = 8;
   localparam int CsrAddrWidth = 5;

   typedef enum logic [2:0] {
      FUNC_TICK  = 3'd0,
      FUNC_RESET = 3'd1,
      FUNC_WRITE = 3'd2,
      FUNC_READ  = 3'd3,
      FUNC_TEMP  = 3'd4
   } func_type;

   typedef enum logic [2:0] {
      REG_RESET_LOW   = 3'd0,
      REG_RESET_REL   = 3'd1,
      REG_PRES_TMO    = 3'd2,
      REG_SLOT_START  = 3'd3,
      REG_WRITE_HOLD  = 3'd4,
      REG_WRITE_REC   = 3'd5,
      REG_READ_SAMPLE = 3'd6,
      REG_READ_HOLD   = 3'd7
   } reg_idx_type;

   typedef enum logic [10:0] {
      PH_IDLE    = 11'b00000000001,
      PH_RST_LOW = 11'b00000000010,
      PH_RST_REL = 11'b00000000100,
      PH_PRES_A  = 11'b00000001000,
      PH_PRES_B  = 11'b00000010000,
      PH_W_START = 11'b00000100000,
      PH_W_HOLD  = 11'b00001000000,
      PH_W_REC   = 11'b00010000000,
      PH_R_START = 11'b00100000000,
      PH_R_WAIT  = 11'b01000000000,
      PH_R_HOLD  = 11'b10000000000
   } phase_type;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NO_PRES  = 2'd1;
   localparam logic [1:0] ST_NO_REL   = 2'd2;
   localparam logic [1:0] ST_REJECTED = 2'd3;

   localparam logic [7:0] CMD_SKIP_ROM  = 8'hCC;
   localparam logic [7:0] CMD_CONVERT   = 8'h44;
   localparam logic [7:0] CMD_READ_PAD  = 8'hBE;
   localparam logic [7:0] BYTE_ALL_ONES = 8'hFF;

   // classified item handed from front to back
   typedef struct packed {
      logic       is_cmd;
      func_type   func;
      logic [7:0] tx_byte;
      logic       bus_in;
   } item_type;

   typedef struct packed {
      logic        bus_out_enable;
      logic        bus_out_level;
      logic        busy_res;
      logic        done_res;
      logic [1:0]  status;
      logic [15:0] rx_data;
      logic [11:0] temp_whole;
      logic [3:0]  temp_frac;
   } result_type;

   typedef struct packed {
      logic [9:0] reset_low;
      logic [7:0] reset_rel;
      logic [9:0] pres_tmo;
      logic [5:0] slot_start;
      logic [7:0] write_hold;
      logic [5:0] write_rec;
      logic [5:0] read_sample;
      logic [7:0] read_hold;
   } timing_type;

endpackage

// File: sv/one_wire_temp_sensor_master_top.sv
// Top level of the single-wire temperature sensor master.
// Depends on owtsm_pkg, owtsm_front, owtsm_back, owtsm_csr.
//
// Usage: push one item per microsecond tick on the req_ channel (func 0 is
// a plain tick, 1..4 start reset, write byte, read byte or read temperature
// while idle). Each accepted item yields exactly one result on the rsp_
// channel, giving the bus drive for the coming tick plus busy, done and
// status; rx_data and the temperature split are valid on the done result.
// Throughput: one item per cycle while the result queue has room; the
// sequencer advances one phase counter step per item. An accepted item
// passes through the front queue register, then the result queue register,
// before it shows on the rsp_ ports, where it can be popped.
// Both channels have two-entry queues; when rsp_pop is held low the result
// queue fills, the sequencer holds, then the front queue fills and req_full
// rises. Nothing is dropped.
// Reset (synchronous, active high) empties both queues, returns the
// sequencer to idle and loads the default timing registers. Registers at
// csr_paddr 4*i are written with psel, penable and pwrite high; pready is
// always high. Write them only while the block is idle.
module one_wire_temp_sensor_master_top #(
   parameter int COUNTER_WIDTH = owtsm_pkg::CounterWidthDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [2:0]  req_func,
   input  logic [7:0]  req_tx_byte,
   input  logic        req_bus_in,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic        rsp_bus_out_enable,
   output logic        rsp_bus_out_level,
   output logic        rsp_busy_res,
   output logic        rsp_done_res,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_rx_data,
   output logic [11:0] rsp_temp_whole,
   output logic [3:0]  rsp_temp_frac,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [owtsm_pkg::CsrAddrWidth-1:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import owtsm_pkg::*;

   item_type   item;
   logic       item_valid, item_take, res_valid;
   result_type res;
   timing_type timing;

   owtsm_front u_front (
      .clock, .reset,
      .push(req_push), .full(req_full),
      .func(req_func), .tx_byte(req_tx_byte), .bus_in(req_bus_in),
      .item_valid, .item_take, .item
   );

   owtsm_back #(.COUNTER_WIDTH(COUNTER_WIDTH)) u_back (
      .clock, .reset,
      .item_valid, .item_take, .item, .timing,
      .res_valid, .res_pop(rsp_pop), .res
   );

   owtsm_csr u_csr (
      .clock, .reset,
      .psel(csr_psel), .penable(csr_penable), .pwrite(csr_pwrite),
      .paddr(csr_paddr), .pwdata(csr_pwdata), .prdata(csr_prdata),
      .timing
   );

   assign csr_pready         = 1'b1;
   assign rsp_empty          = !res_valid;
   assign rsp_bus_out_enable = res.bus_out_enable;
   assign rsp_bus_out_level  = res.bus_out_level;
   assign rsp_busy_res       = res.busy_res;
   assign rsp_done_res       = res.done_res;
   assign rsp_status         = res.status;
   assign rsp_rx_data        = res.rx_data;
   assign rsp_temp_whole     = res.temp_whole;
   assign rsp_temp_frac      = res.temp_frac;
endmodule

// File: sv/owtsm_front.sv
// Front end: accepts items, classifies the command code and queues them.
// Depends on owtsm_pkg.
module owtsm_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                full,
   input  logic [2:0]          func,
   input  logic [7:0]          tx_byte,
   input  logic                bus_in,
   output logic                item_valid,
   input  logic                item_take,
   output owtsm_pkg::item_type item
);
   import owtsm_pkg::*;

   item_type q_ff [2];
   item_type q0_in, q1_in;
   logic [1:0] cnt_ff, cnt_in;
   item_type incoming;
   logic do_push, do_pop;

   always_comb begin
      incoming.is_cmd  = (func >= FUNC_RESET) && (func <= FUNC_TEMP);
      incoming.func    = incoming.is_cmd ? func_type'(func) : FUNC_TICK;
      incoming.tx_byte = tx_byte;
      incoming.bus_in  = bus_in;
   end

   assign full       = (cnt_ff == 2'd2);
   assign do_push    = push && !full;
   assign item_valid = (cnt_ff != 2'd0);
   assign do_pop     = item_valid && item_take;
   assign item       = q_ff[0];

   always_comb begin
      q0_in  = q_ff[0];
      q1_in  = q_ff[1];
      cnt_in = cnt_ff;
      if (do_pop) begin
         q0_in = q_ff[1];
      end
      if (do_push) begin
         if (cnt_ff - {1'b0, do_pop} == 2'd0) begin
            q0_in = incoming;
         end else begin
            q1_in = incoming;
         end
      end
      cnt_in = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      q_ff[0] <= q0_in;
      q_ff[1] <= q1_in;
   end
endmodule

// File: sv/owtsm_back.sv
// Back end: bus sequencer that advances one tick per item and queues results.
// Depends on owtsm_pkg.
module owtsm_back #(
   parameter int COUNTER_WIDTH = owtsm_pkg::CounterWidthDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   item_valid,
   output logic                   item_take,
   input  owtsm_pkg::item_type    item,
   input  owtsm_pkg::timing_type  timing,
   output logic                   res_valid,
   input  logic                   res_pop,
   output owtsm_pkg::result_type  res
);
   import owtsm_pkg::*;

   localparam logic [COUNTER_WIDTH-1:0] CMax = {COUNTER_WIDTH{1'b1}};

   phase_type phase_ff, phase_in;
   logic [COUNTER_WIDTH-1:0] cnt_ff, cnt_in;
   logic [2:0] bit_ff, bit_in;
   logic [7:0] shift_ff, shift_in;
   logic [3:0] step_ff, step_in;
   logic [15:0] word_ff, word_in;
   func_type cmd_ff, cmd_in;
   logic [1:0] last_ff, last_in;

   result_type r_ff [2];
   result_type r0_in, r1_in;
   logic [1:0] rcnt_ff, rcnt_in;
   result_type outr;
   logic [COUNTER_WIDTH-1:0] cnt_inc;
   logic done, is_temp;
   logic [15:0] rx;

   assign item_take = item_valid && (rcnt_ff != 2'd2);
   assign res_valid = (rcnt_ff != 2'd0);
   assign res       = r_ff[0];
   assign cnt_inc   = (cnt_ff < CMax) ? cnt_ff + 1'b1 : cnt_ff;

   // clamp limit to counter range, zero acts as one
   function automatic logic tdone(input logic [COUNTER_WIDTH-1:0] c,
                                  input logic [15:0] lim);
      logic [15:0] l;
      l = lim;
      if (l > 16'(CMax)) l = 16'(CMax);
      if (l == 16'd0) l = 16'd1;
      return 16'(c) >= l;
   endfunction

   always_comb begin
      phase_type pp;
      logic [COUNTER_WIDTH-1:0] pc;
      logic [2:0] pb;
      logic [7:0] ps;
      logic [3:0] pstep;
      logic [15:0] pw;
      logic [1:0] pl;
      logic presence_end, byte_end, temp_go;
      logic [1:0] pst;
      pp = phase_ff; pc = cnt_ff; pb = bit_ff; ps = shift_ff;
      pstep = step_ff; pw = word_ff; pl = last_ff;
      cmd_in = cmd_ff;
      done = 1'b0; is_temp = 1'b0; rx = 16'd0;
      presence_end = 1'b0; byte_end = 1'b0; temp_go = 1'b0; pst = ST_OK;
      if (phase_ff == PH_IDLE) begin
         if (item.is_cmd) begin
            cmd_in = item.func;
            pstep = 4'd0;
            pc = '0;
            unique case (item.func)
               FUNC_WRITE: begin
                  ps = item.tx_byte; pb = 3'd0; pp = PH_W_START;
               end
               FUNC_READ: begin
                  ps = 8'd0; pb = 3'd0; pp = PH_R_START;
               end
               FUNC_TEMP: begin
                  pw = 16'd0; pp = PH_RST_LOW;
               end
               default: pp = PH_RST_LOW;
            endcase
         end
      end else begin
         pc = cnt_inc;
         unique case (phase_ff)
            PH_RST_LOW: if (tdone(cnt_inc, 16'(timing.reset_low))) begin
               pp = PH_RST_REL; pc = '0;
            end
            PH_RST_REL: if (tdone(cnt_inc, 16'(timing.reset_rel))) begin
               pp = PH_PRES_A; pc = '0;
            end
            PH_PRES_A: begin
               if (!item.bus_in) begin
                  pp = PH_PRES_B; pc = '0;
               end else if (tdone(cnt_inc, 16'(timing.pres_tmo))) begin
                  presence_end = 1'b1; pst = ST_NO_PRES;
               end
            end
            PH_PRES_B: begin
               if (item.bus_in) begin
                  presence_end = 1'b1; pst = ST_OK;
               end else if (tdone(cnt_inc, 16'(timing.pres_tmo))) begin
                  presence_end = 1'b1; pst = ST_NO_REL;
               end
            end
            PH_W_START: if (tdone(cnt_inc, 16'(timing.slot_start))) begin
               pp = PH_W_HOLD; pc = '0;
            end
            PH_W_HOLD: if (tdone(cnt_inc, 16'(timing.write_hold))) begin
               pp = PH_W_REC; pc = '0;
            end
            PH_W_REC: if (tdone(cnt_inc, 16'(timing.write_rec))) begin
               if (bit_ff == 3'd7) byte_end = 1'b1;
               else begin
                  pb = bit_ff + 3'd1; ps = shift_ff >> 1; pp = PH_W_START; pc = '0;
               end
            end
            PH_R_START: if (tdone(cnt_inc, 16'(timing.slot_start))) begin
               pp = PH_R_WAIT; pc = '0;
            end
            PH_R_WAIT: if (tdone(cnt_inc, 16'(timing.read_sample))) begin
               ps = {item.bus_in, shift_ff[7:1]}; pp = PH_R_HOLD; pc = '0;
            end
            PH_R_HOLD: if (tdone(cnt_inc, 16'(timing.read_hold))) begin
               if (bit_ff == 3'd7) byte_end = 1'b1;
               else begin
                  pb = bit_ff + 3'd1; pp = PH_R_START; pc = '0;
               end
            end
            default: begin
               pp = PH_IDLE; pc = '0;
            end
         endcase
         if (presence_end) begin
            if (cmd_ff == FUNC_RESET) begin
               done = 1'b1; pl = pst; pp = PH_IDLE; pc = '0;
            end else temp_go = 1'b1;
         end
         if (byte_end) begin
            if (cmd_ff == FUNC_WRITE) begin
               done = 1'b1; pl = ST_OK; pp = PH_IDLE; pc = '0;
            end else if (cmd_ff == FUNC_READ) begin
               done = 1'b1; pl = ST_OK; rx = {8'd0, ps}; pp = PH_IDLE; pc = '0;
            end else temp_go = 1'b1;
         end
         if (temp_go) begin
            pc = '0;
            priority case (step_ff)
               4'd0: begin pstep = 4'd1; ps = CMD_SKIP_ROM; pb = 3'd0; pp = PH_W_START; end
               4'd1: begin pstep = 4'd2; ps = CMD_CONVERT; pb = 3'd0; pp = PH_W_START; end
               4'd2: begin pstep = 4'd3; ps = 8'd0; pb = 3'd0; pp = PH_R_START; end
               4'd3: begin
                  if (ps == BYTE_ALL_ONES) begin
                     pstep = 4'd4; pp = PH_RST_LOW;
                  end else begin
                     ps = 8'd0; pb = 3'd0; pp = PH_R_START;
                  end
               end
               4'd4: begin pstep = 4'd5; ps = CMD_SKIP_ROM; pb = 3'd0; pp = PH_W_START; end
               4'd5: begin pstep = 4'd6; ps = CMD_READ_PAD; pb = 3'd0; pp = PH_W_START; end
               4'd6: begin pstep = 4'd7; ps = 8'd0; pb = 3'd0; pp = PH_R_START; end
               4'd7: begin
                  pw = {8'd0, ps}; pstep = 4'd8; ps = 8'd0; pb = 3'd0; pp = PH_R_START;
               end
               default: begin
                  pw = {ps, word_ff[7:0]}; pstep = 4'd0;
                  done = 1'b1; is_temp = 1'b1; pl = ST_OK; rx = pw; pp = PH_IDLE;
               end
            endcase
         end
      end
      phase_in = pp; cnt_in = pc; bit_in = pb; shift_in = ps;
      step_in = pstep; word_in = pw; last_in = pl;

      outr.bus_out_enable = (pp == PH_RST_LOW) || (pp == PH_W_START) ||
                            (pp == PH_R_START) || ((pp == PH_W_HOLD) && !ps[0]);
      outr.bus_out_level  = 1'b0;
      outr.busy_res       = (pp != PH_IDLE);
      outr.done_res       = done;
      outr.status         = ((phase_ff != PH_IDLE) && item.is_cmd) ? ST_REJECTED : pl;
      outr.rx_data        = rx;
      outr.temp_whole     = is_temp ? rx[15:4] : 12'd0;
      outr.temp_frac      = is_temp ? rx[3:0] : 4'd0;
   end

   always_comb begin
      logic take;
      take   = res_valid && res_pop;
      r0_in  = r_ff[0];
      r1_in  = r_ff[1];
      if (take) r0_in = r_ff[1];
      if (item_take) begin
         if (rcnt_ff - {1'b0, take} == 2'd0) r0_in = outr;
         else r1_in = outr;
      end
      rcnt_in = rcnt_ff + {1'b0, item_take} - {1'b0, take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         cnt_ff   <= '0;
         bit_ff   <= 3'd0;
         shift_ff <= 8'd0;
         step_ff  <= 4'd0;
         word_ff  <= 16'd0;
         cmd_ff   <= FUNC_TICK;
         last_ff  <= ST_OK;
         rcnt_ff  <= 2'd0;
      end else begin
         if (item_take) begin
            phase_ff <= phase_in;
            cnt_ff   <= cnt_in;
            bit_ff   <= bit_in;
            shift_ff <= shift_in;
            step_ff  <= step_in;
            word_ff  <= word_in;
            cmd_ff   <= cmd_in;
            last_ff  <= last_in;
         end
         rcnt_ff <= rcnt_in;
      end
      r_ff[0] <= r0_in;
      r_ff[1] <= r1_in;
   end
endmodule

// File: sv/owtsm_csr.sv
// Timing register file behind the APB-style configuration port.
// Depends on owtsm_pkg.
module owtsm_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [owtsm_pkg::CsrAddrWidth-1:0] paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output owtsm_pkg::timing_type         timing
);
   import owtsm_pkg::*;

   timing_type t_ff;
   reg_idx_type idx;
   logic wr;

   assign idx    = reg_idx_type'(paddr[4:2]);
   assign wr     = psel && penable && pwrite;
   assign timing = t_ff;

   always_comb begin
      unique case (idx)
         REG_RESET_LOW:   prdata = 32'(t_ff.reset_low);
         REG_RESET_REL:   prdata = 32'(t_ff.reset_rel);
         REG_PRES_TMO:    prdata = 32'(t_ff.pres_tmo);
         REG_SLOT_START:  prdata = 32'(t_ff.slot_start);
         REG_WRITE_HOLD:  prdata = 32'(t_ff.write_hold);
         REG_WRITE_REC:   prdata = 32'(t_ff.write_rec);
         REG_READ_SAMPLE: prdata = 32'(t_ff.read_sample);
         default:         prdata = 32'(t_ff.read_hold);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t_ff.reset_low   <= 10'd750;
         t_ff.reset_rel   <= 8'd15;
         t_ff.pres_tmo    <= 10'd240;
         t_ff.slot_start  <= 6'd2;
         t_ff.write_hold  <= 8'd60;
         t_ff.write_rec   <= 6'd2;
         t_ff.read_sample <= 6'd10;
         t_ff.read_hold   <= 8'd60;
      end else if (wr) begin
         unique case (idx)
            REG_RESET_LOW:   t_ff.reset_low   <= pwdata[9:0];
            REG_RESET_REL:   t_ff.reset_rel   <= pwdata[7:0];
            REG_PRES_TMO:    t_ff.pres_tmo    <= pwdata[9:0];
            REG_SLOT_START:  t_ff.slot_start  <= pwdata[5:0];
            REG_WRITE_HOLD:  t_ff.write_hold  <= pwdata[7:0];
            REG_WRITE_REC:   t_ff.write_rec   <= pwdata[5:0];
            REG_READ_SAMPLE: t_ff.read_sample <= pwdata[5:0];
            default:         t_ff.read_hold   <= pwdata[7:0];
         endcase
      end
   end
endmodule

// File: sv/owtsm_checker.sv
// Port-level checker for the single-wire temperature sensor master.
// Depends on one_wire_temp_sensor_master_top; bound to it below.
module owtsm_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic        rsp_bus_out_level,
   input logic        rsp_done_res,
   input logic [15:0] rsp_rx_data,
   input logic [11:0] rsp_temp_whole,
   input logic [3:0]  rsp_temp_frac
);
   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> rsp_empty) else $error("result queue not empty after reset");
   a_level_low: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> !rsp_bus_out_level) else $error("bus level driven high");
   a_rx_only_done: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_done_res) |-> (rsp_rx_data == 16'd0))
      else $error("rx data outside done");
   a_temp_split: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_temp_whole != 12'd0) |->
      (rsp_temp_whole == rsp_rx_data[15:4])) else $error("temperature split wrong");
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> !rsp_empty) else $error("result lost while stalled");
endmodule

bind one_wire_temp_sensor_master_top owtsm_checker u_owtsm_checker (
   .clock, .reset, .rsp_empty, .rsp_pop, .rsp_bus_out_level,
   .rsp_done_res, .rsp_rx_data, .rsp_temp_whole, .rsp_temp_frac
);

// File: tb/one_wire_temp_sensor_master_top_test.sv
// Self-checking testbench for one_wire_temp_sensor_master_top.
// Drives tick and command items against a behavioral bus sensor, predicts each
// result in-bench and compares it in order. Depends on owtsm_pkg.
`timescale 1ns / 1ps

module one_wire_temp_sensor_master_top_test;
   import owtsm_pkg::*;

   localparam int CMax = 1023;
   localparam int IdleLimit = 20000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [2:0]  req_func = FUNC_TICK;
   logic [7:0]  req_tx_byte = 8'd0;
   logic        req_bus_in = 1'b1;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic        rsp_bus_out_enable, rsp_bus_out_level, rsp_busy_res, rsp_done_res;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_rx_data;
   logic [11:0] rsp_temp_whole;
   logic [3:0]  rsp_temp_frac;
   logic        csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [CsrAddrWidth-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   one_wire_temp_sensor_master_top u_dut (.*);

   always #2 clock = ~clock;

   // sequencer mirror
   typedef enum int {
      S_IDLE, S_RST_LOW, S_RST_REL, S_PRES_A, S_PRES_B, S_W_START, S_W_HOLD,
      S_W_REC, S_R_START, S_R_WAIT, S_R_HOLD
   } seq_phase_type;

   int unsigned timing [8];
   seq_phase_type ph;
   int unsigned cnt, bit_idx, shreg, step, tword, active, last_st;
   bit          r_done;
   int unsigned r_rx, r_whole, r_frac;

   result_type  expected_results [$];
   int          mismatches = 0;
   int          idle_cycles = 0;
   int          idle_pct = 31;
   bit          hold_rsp = 1'b0;
   int unsigned temp_bytes [$];   // bytes the sensor model returns on reads
   int          pres_mode = 0;    // 0 good, 1 absent, 2 stuck low

   function automatic void go(seq_phase_type p);
      ph = p;
      cnt = 0;
   endfunction

   function automatic bit ticked(int unsigned lim);
      if (lim > CMax) lim = CMax;
      if (lim == 0) lim = 1;
      if (cnt < CMax) cnt++;
      return cnt >= lim;
   endfunction

   function automatic void start_write(int unsigned b);
      shreg = b & 8'hFF;
      bit_idx = 0;
      go(S_W_START);
   endfunction

   function automatic void start_read();
      shreg = 0;
      bit_idx = 0;
      go(S_R_START);
   endfunction

   function automatic void complete(int unsigned st, int unsigned rx, bit is_temp);
      go(S_IDLE);
      last_st = st & 3;
      r_done = 1;
      r_rx = rx & 16'hFFFF;
      if (is_temp) begin
         r_whole = (rx >> 4) & 12'hFFF;
         r_frac = rx & 4'hF;
      end
   endfunction

   function automatic void temp_advance();
      case (step)
         0: begin step = 1; start_write(CMD_SKIP_ROM); end
         1: begin step = 2; start_write(CMD_CONVERT); end
         2: begin step = 3; start_read(); end
         3: begin
            if (shreg == BYTE_ALL_ONES) begin step = 4; go(S_RST_LOW); end
            else start_read();
         end
         4: begin step = 5; start_write(CMD_SKIP_ROM); end
         5: begin step = 6; start_write(CMD_READ_PAD); end
         6: begin step = 7; start_read(); end
         7: begin tword = shreg; step = 8; start_read(); end
         default: begin
            tword = (tword & 8'hFF) | (shreg << 8);
            step = 0;
            complete(ST_OK, tword, 1'b1);
         end
      endcase
   endfunction

   function automatic void presence_over(int unsigned st);
      if (active == FUNC_RESET) complete(st, 0, 1'b0);
      else temp_advance();
   endfunction

   function automatic void byte_over();
      if (active == FUNC_WRITE) complete(ST_OK, 0, 1'b0);
      else if (active == FUNC_READ) complete(ST_OK, shreg, 1'b0);
      else temp_advance();
   endfunction

   function automatic void sequencer_tick(bit b);
      case (ph)
         S_RST_LOW: if (ticked(timing[REG_RESET_LOW])) go(S_RST_REL);
         S_RST_REL: if (ticked(timing[REG_RESET_REL])) go(S_PRES_A);
         S_PRES_A: begin
            if (!b) go(S_PRES_B);
            else if (ticked(timing[REG_PRES_TMO])) presence_over(ST_NO_PRES);
         end
         S_PRES_B: begin
            if (b) presence_over(ST_OK);
            else if (ticked(timing[REG_PRES_TMO])) presence_over(ST_NO_REL);
         end
         S_W_START: if (ticked(timing[REG_SLOT_START])) go(S_W_HOLD);
         S_W_HOLD: if (ticked(timing[REG_WRITE_HOLD])) go(S_W_REC);
         S_W_REC: if (ticked(timing[REG_WRITE_REC])) begin
            if (bit_idx >= 7) byte_over();
            else begin bit_idx++; shreg >>= 1; go(S_W_START); end
         end
         S_R_START: if (ticked(timing[REG_SLOT_START])) go(S_R_WAIT);
         S_R_WAIT: if (ticked(timing[REG_READ_SAMPLE])) begin
            shreg = ((shreg >> 1) | (b << 7)) & 8'hFF;
            go(S_R_HOLD);
         end
         S_R_HOLD: if (ticked(timing[REG_READ_HOLD])) begin
            if (bit_idx >= 7) byte_over();
            else begin bit_idx++; go(S_R_START); end
         end
         default: go(S_IDLE);
      endcase
   endfunction

   function automatic result_type predict_result(logic [2:0] f, logic [7:0] tx, logic b);
      result_type r;
      bit is_cmd, rej;
      is_cmd = (f >= FUNC_RESET) && (f <= FUNC_TEMP);
      rej = 1'b0;
      r_done = 0; r_rx = 0; r_whole = 0; r_frac = 0;
      if (ph == S_IDLE) begin
         if (is_cmd) begin
            active = f;
            step = 0;
            if (f == FUNC_RESET || f == FUNC_TEMP) begin
               if (f == FUNC_TEMP) tword = 0;
               go(S_RST_LOW);
            end else if (f == FUNC_WRITE) start_write(tx);
            else start_read();
         end
      end else begin
         rej = is_cmd;
         sequencer_tick(b);
      end
      r.bus_out_enable = (ph == S_RST_LOW || ph == S_W_START || ph == S_R_START ||
                          (ph == S_W_HOLD && !shreg[0]));
      r.bus_out_level = 1'b0;
      r.busy_res = (ph != S_IDLE);
      r.done_res = r_done;
      r.status = rej ? ST_REJECTED : last_st[1:0];
      r.rx_data = r_rx[15:0];
      r.temp_whole = r_whole[11:0];
      r.temp_frac = r_frac[3:0];
      return r;
   endfunction

   // sensor stand-in: chooses bus_in for the next item from the mirror phase
   function automatic logic sensor_level();
      if (ph == S_PRES_A || ph == S_PRES_B) begin
         if (pres_mode == 1) return 1'b1;
         if (pres_mode == 2) return 1'b0;
         return (ph == S_PRES_A) ? 1'b0 : ($urandom_range(0, 3) == 0);
      end
      if (ph == S_R_WAIT && temp_bytes.size() > 0)
         return temp_bytes[0][bit_idx];
      return 1'($urandom_range(0, 1));
   endfunction

   function automatic void sensor_track();
      if (ph == S_R_HOLD && bit_idx >= 7 && cnt == 0 && temp_bytes.size() > 0)
         void'(temp_bytes.pop_front());
   endfunction

   // push stays high after a transfer; drain drops it, and the next call drops it for idle gaps
   task automatic send_item(logic [2:0] f, logic [7:0] tx, logic b);
      while (!hold_rsp && $urandom_range(0, 99) < idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_func <= f;
      req_tx_byte <= tx;
      req_bus_in <= b;
      @(posedge clock);
      while (req_full) @(posedge clock);
      expected_results.push_back(predict_result(f, tx, b));
      sensor_track();
   endtask

   task automatic send_tick();
      send_item(FUNC_TICK, 8'($urandom_range(0, 255)), sensor_level());
   endtask

   task automatic run_until_idle();
      do send_tick(); while (ph != S_IDLE);
   endtask

   task automatic drain();
      req_push <= 1'b0;
      while (expected_results.size() > 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_reg(reg_idx_type idx, int unsigned val);
      csr_psel <= 1'b1; csr_penable <= 1'b0; csr_pwrite <= 1'b1;
      csr_paddr <= CsrAddrWidth'(4 * idx); csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      timing[idx] = val & ((idx == REG_RESET_LOW || idx == REG_PRES_TMO) ? 10'h3FF :
                           (idx == REG_RESET_REL || idx == REG_WRITE_HOLD ||
                            idx == REG_READ_HOLD) ? 8'hFF : 6'h3F);
      @(posedge clock);
   endtask

   task automatic set_fast_timing(bit zeros);
      for (int i = 0; i < NumRegs; i++)
         write_reg(reg_idx_type'(i), zeros ? 0 : $urandom_range(1, 3));
   endtask

   task automatic queue_temp_bytes(int polls);
      temp_bytes.delete();
      for (int i = 0; i < polls; i++) temp_bytes.push_back($urandom_range(0, 254));
      temp_bytes.push_back(BYTE_ALL_ONES);
      temp_bytes.push_back($urandom_range(0, 255));
      temp_bytes.push_back($urandom_range(0, 255));
   endtask

   // result checker
   always @(posedge clock) begin
      result_type got, exp_r;
      if (!reset && rsp_pop && !rsp_empty) begin
         got = {rsp_bus_out_enable, rsp_bus_out_level, rsp_busy_res, rsp_done_res,
                rsp_status, rsp_rx_data, rsp_temp_whole, rsp_temp_frac};
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", got);
         end else begin
            exp_r = expected_results.pop_front();
            if (got !== exp_r) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %h actual %h", exp_r, got);
            end
         end
      end
   end

   // receiver
   always @(posedge clock) begin
      if (reset || hold_rsp) rsp_pop <= 1'b0;
      else rsp_pop <= ($urandom_range(0, 99) >= idle_pct);
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty) || reset) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
         $display("one_wire_temp_sensor_master_top_test NOT OK");
         $finish;
      end
   end

   task automatic test_directed();
      // all-zero durations, then each command in turn
      set_fast_timing(1'b1);
      pres_mode = 0; send_item(FUNC_RESET, 8'h00, 1'b1); run_until_idle();
      pres_mode = 1; send_item(FUNC_RESET, 8'hFF, 1'b0); run_until_idle();
      pres_mode = 2; send_item(FUNC_RESET, 8'h00, 1'b1); run_until_idle();
      pres_mode = 0;
      send_item(FUNC_WRITE, 8'hFF, 1'b0);
      send_item(FUNC_READ, 8'h00, 1'b1);   // rejected while busy
      run_until_idle();
      send_item(FUNC_WRITE, 8'h00, 1'b1); run_until_idle();
      send_item(FUNC_READ, 8'hA5, 1'b0); run_until_idle();
      send_item(3'd7, 8'h00, 1'b0);        // unused code acts as a tick
      send_item(3'd5, 8'hFF, 1'b1);
      queue_temp_bytes(1);
      send_item(FUNC_TEMP, 8'h00, 1'b1); run_until_idle();
      drain();
   endtask

   task automatic test_max_timing();
      // upper pwdata bits beyond each field are dropped by the register
      write_reg(REG_RESET_LOW, 32'hFFFF_FC04); write_reg(REG_RESET_REL, 8'hFF);
      write_reg(REG_PRES_TMO, 32'hFFFF_FC06); write_reg(REG_SLOT_START, 6'h3F);
      write_reg(REG_WRITE_HOLD, 8'hFF); write_reg(REG_WRITE_REC, 6'h3F);
      write_reg(REG_READ_SAMPLE, 6'h3F); write_reg(REG_READ_HOLD, 8'hFF);
      pres_mode = 1;
      send_item(FUNC_RESET, 8'h00, 1'b1); run_until_idle();
      pres_mode = 0;
      drain();
   endtask

   task automatic test_backpressure();
      set_fast_timing(1'b0);
      fork
         begin
            hold_rsp = 1'b1;
            repeat (60) @(posedge clock);
            hold_rsp = 1'b0;
         end
         begin
            send_item(FUNC_WRITE, 8'($urandom_range(0, 255)), 1'b1);
            repeat (20) send_tick();
         end
      join
      run_until_idle();
      drain();
   endtask

   task automatic test_random();
      int unsigned cmd;
      for (int phase_no = 0; phase_no < 4; phase_no++) begin
         set_fast_timing(phase_no == 3);
         idle_pct = (phase_no == 2) ? 0 : 31;
         for (int n = 0; n < 2; n++) begin
            cmd = $urandom_range(1, 4);
            pres_mode = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 2) : 0;
            if (cmd == FUNC_TEMP) queue_temp_bytes($urandom_range(0, 2));
            send_item(3'(cmd), 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            while (ph != S_IDLE) begin
               if ($urandom_range(0, 15) == 0)
                  send_item(3'($urandom_range(1, 7)), 8'($urandom_range(0, 255)),
                            sensor_level());
               else send_tick();
            end
            repeat ($urandom_range(0, 2)) send_item(($urandom_range(0, 7) == 0) ? 3'd6 :
                                                      FUNC_TICK, 8'($urandom_range(0, 255)),
                                                      1'($urandom_range(0, 1)));
         end
         drain();
      end
      idle_pct = 31;
   endtask

   initial begin
      for (int i = 0; i < NumRegs; i++) timing[i] = 0;
      timing[REG_RESET_LOW] = 750; timing[REG_RESET_REL] = 15; timing[REG_PRES_TMO] = 240;
      timing[REG_SLOT_START] = 2; timing[REG_WRITE_HOLD] = 60; timing[REG_WRITE_REC] = 2;
      timing[REG_READ_SAMPLE] = 10; timing[REG_READ_HOLD] = 60;
      ph = S_IDLE; cnt = 0; bit_idx = 0; shreg = 0; step = 0; tword = 0;
      active = 0; last_st = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_max_timing();
      test_backpressure();
      test_random();
      drain();
      if (mismatches == 0 && expected_results.size() == 0)
         $display("one_wire_temp_sensor_master_top_test OK");
      else
         $display("one_wire_temp_sensor_master_top_test NOT OK");
      $finish;
   end

endmodule

// File: files.f
sv/owtsm_pkg.sv
sv/owtsm_front.sv
sv/owtsm_back.sv
sv/owtsm_csr.sv
sv/one_wire_temp_sensor_master_top.sv
sv/owtsm_checker.sv
tb/one_wire_temp_sensor_master_top_test.sv
